>>> rtl/msrim_pkg.sv
// Shared types and constants of the multi-stage ring index manager.
package msrim_pkg;

    // Field widths fixed by the interface
    localparam int CMD_W     = 3;
    localparam int STAGE_W   = 3;
    localparam int FIELD_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = 32;
    localparam int RLEN_W    = 11;
    localparam int SCNT_W    = 4;
    localparam int BYTES_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_GET       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PRE_GET   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNCHECKED = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PUT       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REINIT    = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_SHORT     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_AT_ZERO   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BASE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES = 2'd3;

    // Configuration reset values
    localparam logic [RLEN_W-1:0]  RST_RING_LENGTH   = 11'd1024;
    localparam logic [SCNT_W-1:0]  RST_STAGE_COUNT   = 4'd3;
    localparam logic [ADDR_W-1:0]  RST_ELEMENT_BASE  = 32'd0;
    localparam logic [BYTES_W-1:0] RST_ELEMENT_BYTES = 13'd64;

    // One request
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [STAGE_W-1:0] stage;
        logic [FIELD_W-1:0] amount;
    } req_t;

    // One response
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   element_address;
        logic [FIELD_W-1:0]  element_index;
        logic [FIELD_W-1:0]  held_count;
        logic [FIELD_W-1:0]  contiguous_count;
        logic                empty_flag;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic read;
        logic calc;
        logic load;
    } ctl_t;

endpackage

>>> rtl/msrim_ctrl.sv
// Sequencing state machine and handshake control of the ring index manager.
module msrim_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output msrim_pkg::ctl_t   ctl
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_CALC   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    // Datapath commands
    always_comb
    begin
        ctl.capture = (state_reg == ST_IDLE) && req_valid;
        ctl.read    = (state_reg == ST_READ);
        ctl.calc    = (state_reg == ST_CALC);
        ctl.load    = (state_reg == ST_FINISH) && (!rsp_valid_reg || !rsp_stall);
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_READ;
            end
            ST_READ:   state_next = ST_CALC;
            ST_CALC:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (ctl.load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.load)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> rtl/msrim_dp.sv
// Index tables, configuration registers and arithmetic of the ring index manager.
module msrim_dp
#(
    parameter int MAX_STAGES = 8,
    parameter int MAX_RING   = 1024
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  msrim_pkg::req_t                      req,
    input  msrim_pkg::ctl_t                      ctl,
    input  logic                                 cfg_we,
    input  logic [msrim_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msrim_pkg::CFG_DATA_W-1:0]     cfg_data,
    output msrim_pkg::rsp_t                      rsp
);

    localparam int FW    = msrim_pkg::FIELD_W;
    localparam int IDX_W = $clog2(MAX_RING);
    localparam int LEN_W = $clog2(MAX_RING + 1);
    localparam int CNT_W = ((LEN_W > FW) ? LEN_W : FW) + 1;
    localparam int SW    = $clog2(MAX_STAGES);
    localparam int STW   = $clog2(MAX_STAGES + 1);
    localparam int PW    = IDX_W + msrim_pkg::BYTES_W;
    localparam int AW    = msrim_pkg::ADDR_W;
    localparam int NSEL  = 1 << msrim_pkg::STAGE_W;

    // Configuration registers
    logic [msrim_pkg::RLEN_W-1:0]  ring_length_reg;
    logic [msrim_pkg::SCNT_W-1:0]  stage_count_reg;
    logic [AW-1:0]                 element_base_reg;
    logic [msrim_pkg::BYTES_W-1:0] element_bytes_reg;

    // Per-stage index tables
    logic [IDX_W-1:0] in_tbl_reg  [MAX_STAGES];
    logic [IDX_W-1:0] out_tbl_reg [MAX_STAGES];

    // Request and intermediate results
    msrim_pkg::req_t               req_reg;
    logic [IDX_W-1:0]              ii_reg;
    logic [IDX_W-1:0]              oi_reg;
    logic [PW-1:0]                 prod_reg;
    logic [PW-1:0]                 prod_next;
    logic [msrim_pkg::STATUS_W-1:0] status_reg;
    logic [msrim_pkg::STATUS_W-1:0] status_next;
    logic [FW-1:0]                 held_reg;
    logic [FW-1:0]                 cont_reg;
    logic                          empty_reg;
    logic                          addr_en_reg;
    logic                          addr_en_next;
    msrim_pkg::rsp_t               rsp_reg;
    msrim_pkg::rsp_t               rsp_next;

    logic [LEN_W-1:0] len_eff;
    logic [STW-1:0]   stages_eff;
    logic [SW-1:0]    s_sel;
    logic [STW-1:0]   nx_w;
    logic [SW-1:0]    nx_sel;
    logic [SW-1:0]    rd_sel;
    logic [IDX_W-1:0] in_rd;
    logic [CNT_W-1:0] amt_w;
    logic [CNT_W-1:0] len_w;
    logic [CNT_W-1:0] ii_w;
    logic [CNT_W-1:0] oi_w;
    logic [CNT_W-1:0] held_w;
    logic [CNT_W-1:0] cont_w;
    logic [CNT_W-1:0] adv_sum;
    logic [IDX_W-1:0] adv_idx;
    logic             range_cmd;
    logic             too_big;
    logic             short_amt;
    logic             out_we;
    logic             in_we;
    logic             restart;

    // Effective ring length and stage count, clamped
    always_comb
    begin
        if (ring_length_reg < 11'd2)
            len_eff = LEN_W'(2);
        else if (ring_length_reg > MAX_RING)
            len_eff = LEN_W'(MAX_RING);
        else
            len_eff = LEN_W'(ring_length_reg);

        if (stage_count_reg < 4'd2)
            stages_eff = STW'(2);
        else if (stage_count_reg > MAX_STAGES)
            stages_eff = STW'(MAX_STAGES);
        else
            stages_eff = STW'(stage_count_reg);
    end

    // Addressed stage, folded into the table depth
    always_comb
    begin
        s_sel = '0;
        for (int i = 0; i < NSEL; i++)
        begin
            if (req_reg.stage == msrim_pkg::STAGE_W'(i))
                s_sel = SW'(i % MAX_STAGES);
        end
    end

    // Following stage; the last one hands on to stage zero
    always_comb
    begin
        nx_w = STW'(s_sel) + STW'(1);
        if ((nx_w >= stages_eff) || (nx_w >= MAX_STAGES))
            nx_sel = '0;
        else
            nx_sel = SW'(nx_w);
    end

    // Single in-table read port: own stage first, then the following stage
    assign rd_sel = ctl.calc ? nx_sel : s_sel;
    assign in_rd  = in_tbl_reg[rd_sel];

    // Counts and command decision
    always_comb
    begin
        amt_w = CNT_W'(req_reg.amount);
        len_w = CNT_W'(len_eff);
        ii_w  = CNT_W'(ii_reg);
        oi_w  = CNT_W'(oi_reg);

        if (ii_w >= oi_w)
        begin
            held_w = ii_w - oi_w;
            cont_w = ii_w - oi_w;
        end
        else
        begin
            held_w = len_w + ii_w - oi_w;
            cont_w = len_w - oi_w;
        end

        range_cmd = req_reg.cmd inside {msrim_pkg::CMD_GET, msrim_pkg::CMD_PRE_GET,
                                        msrim_pkg::CMD_UNCHECKED, msrim_pkg::CMD_PUT};
        too_big   = range_cmd && (amt_w > (len_w - CNT_W'(1)));
        short_amt = amt_w > held_w;

        status_next  = msrim_pkg::STAT_OK;
        addr_en_next = 1'b0;
        out_we       = 1'b0;
        in_we        = 1'b0;
        if (too_big)
            status_next = msrim_pkg::STAT_TOO_LARGE;
        else
        begin
            case (req_reg.cmd)
                msrim_pkg::CMD_GET:
                begin
                    if (short_amt)
                        status_next = msrim_pkg::STAT_SHORT;
                    else
                    begin
                        addr_en_next = 1'b1;
                        out_we       = 1'b1;
                    end
                end
                msrim_pkg::CMD_PRE_GET:
                begin
                    if (short_amt)
                        status_next = msrim_pkg::STAT_SHORT;
                    else if (oi_reg == '0)
                        status_next = msrim_pkg::STAT_AT_ZERO;
                end
                msrim_pkg::CMD_UNCHECKED:
                begin
                    addr_en_next = 1'b1;
                    out_we       = 1'b1;
                end
                msrim_pkg::CMD_PUT:
                begin
                    in_we = 1'b1;
                end
                default:
                begin
                    status_next = msrim_pkg::STAT_OK;
                end
            endcase
        end
    end

    // Shared wrap-around advance: out-index for gets, next in-index for puts
    always_comb
    begin
        if (req_reg.cmd == msrim_pkg::CMD_PUT)
            adv_sum = CNT_W'(in_rd) + amt_w;
        else
            adv_sum = oi_w + amt_w;
        if (adv_sum >= len_w)
            adv_sum = adv_sum - len_w;
        adv_idx = IDX_W'(adv_sum);
    end

    assign prod_next = PW'(oi_reg) * PW'(element_bytes_reg);

    assign restart = (cfg_we && (cfg_index inside {msrim_pkg::CFG_RING_LENGTH,
                                                   msrim_pkg::CFG_STAGE_COUNT}))
                   || (ctl.calc && (req_reg.cmd == msrim_pkg::CMD_REINIT));

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_length_reg   <= msrim_pkg::RST_RING_LENGTH;
            stage_count_reg   <= msrim_pkg::RST_STAGE_COUNT;
            element_base_reg  <= msrim_pkg::RST_ELEMENT_BASE;
            element_bytes_reg <= msrim_pkg::RST_ELEMENT_BYTES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                msrim_pkg::CFG_RING_LENGTH:
                    ring_length_reg <= cfg_data[msrim_pkg::RLEN_W-1:0];
                msrim_pkg::CFG_STAGE_COUNT:
                    stage_count_reg <= cfg_data[msrim_pkg::SCNT_W-1:0];
                msrim_pkg::CFG_ELEMENT_BASE:
                    element_base_reg <= cfg_data[AW-1:0];
                msrim_pkg::CFG_ELEMENT_BYTES:
                    element_bytes_reg <= cfg_data[msrim_pkg::BYTES_W-1:0];
                default:
                    element_base_reg <= element_base_reg;
            endcase
        end
    end

    // Index tables: stage zero starts full (in-index 0, out-index 1), all others empty at 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                in_tbl_reg[i]  <= (i == 0) ? '0 : IDX_W'(1);
                out_tbl_reg[i] <= IDX_W'(1);
            end
        end
        else if (restart)
        begin
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                in_tbl_reg[i]  <= (i == 0) ? '0 : IDX_W'(1);
                out_tbl_reg[i] <= IDX_W'(1);
            end
        end
        else if (ctl.calc)
        begin
            if (out_we)
                out_tbl_reg[s_sel] <= adv_idx;
            if (in_we)
                in_tbl_reg[nx_sel] <= adv_idx;
        end
    end

    // Request capture and pipeline of intermediates
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
            req_reg <= req;
        if (ctl.read)
        begin
            ii_reg <= in_rd;
            oi_reg <= out_tbl_reg[s_sel];
        end
        if (ctl.calc)
        begin
            prod_reg    <= prod_next;
            status_reg  <= status_next;
            held_reg    <= FW'(held_w);
            cont_reg    <= FW'(cont_w);
            empty_reg   <= (ii_reg == oi_reg);
            addr_en_reg <= addr_en_next;
        end
        if (ctl.load)
            rsp_reg <= rsp_next;
    end

    // Response assembly
    always_comb
    begin
        rsp_next.status           = status_reg;
        rsp_next.element_address  = addr_en_reg ? (element_base_reg + AW'(prod_reg)) : '0;
        rsp_next.element_index    = FW'(oi_reg);
        rsp_next.held_count       = held_reg;
        rsp_next.contiguous_count = cont_reg;
        rsp_next.empty_flag       = empty_reg;
    end

    assign rsp = rsp_reg;

endmodule

>>> rtl/multi_stage_ring_index_manager.sv
// Top level of the multi-stage ring index manager.
// Sequence: an accepted request passes through the read, calculate and load steps
// of the sequencer before its response is registered, and a new request is taken
// only when the sequencer is idle again; a stalled response holds it in its last step.
// Reset: asynchronous, active low; restores the sequencer, configuration and index tables at once.
module multi_stage_ring_index_manager
#(
    parameter int MAX_STAGES = 8,
    parameter int MAX_RING   = 1024
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  msrim_pkg::req_t                      req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output msrim_pkg::rsp_t                      rsp,
    input  logic                                 cfg_we,
    input  logic [msrim_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msrim_pkg::CFG_DATA_W-1:0]     cfg_data
);

    msrim_pkg::ctl_t ctl;

    // Sequencer
    msrim_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    // Tables and arithmetic
    msrim_dp
    #(
        .MAX_STAGES (MAX_STAGES),
        .MAX_RING   (MAX_RING)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

    // One request at a time: the port closes right after an acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted while another is in flight");

    // Sequencer steps never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.capture, ctl.read, ctl.calc, ctl.load}))
        else $error("overlapping sequencer commands");

    // A loaded response is offered on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> rsp_valid)
        else $error("loaded response not presented");

    // Only successful gets carry an address
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != msrim_pkg::STAT_OK)) |-> (rsp.element_address == '0))
        else $error("address given on a failed request");

endmodule
